FILE: rtl/core/packet_mode_deframer_unit_defines.svh
// assertion macros for the packet mode deframer
// used by packet_mode_deframer_unit.sv, expects clk and rst_n in scope
`ifndef PACKET_MODE_DEFRAMER_UNIT_DEFINES_SVH
`define PACKET_MODE_DEFRAMER_UNIT_DEFINES_SVH

// check holds in the same cycle as the condition
`define PMD_ASSERT_NOW(lbl, cond, check) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error("%m: same-cycle check failed");

// check holds in the cycle after the condition
`define PMD_ASSERT_NEXT(lbl, cond, check) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: rtl/core/pmd_pkg.sv
// types, constants and the byte-wide crc function of the packet mode deframer
// no dependencies; used by the result channel interface and the top level
package pmd_pkg;

    localparam int unsigned NUM_STREAMS = 4;
    localparam int unsigned ID_W        = 2;
    localparam int unsigned POS_W       = 9;

    localparam logic [7:0]  PACKET_LEN_RESET = 8'd10;
    localparam logic [15:0] CRC_PRESET       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;
    localparam logic [2:0]  SEQ_MASK         = 3'd7;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // header byte bit positions
    localparam int unsigned HDR_FIRST = 7;
    localparam int unsigned HDR_LAST  = 6;
    localparam int unsigned HDR_ID_HI = 5;
    localparam int unsigned HDR_ID_LO = 4;
    localparam int unsigned HDR_PAD   = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_start;
    } pmd_item_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] stream_id;
        logic [7:0]      payload;
        logic            crc_good;
        logic            first_mark;
        logic            last_mark;
        logic            sequence_good;
        logic            length_error;
        logic            unit_complete;
    } pmd_result_t;

    // ccitt crc, msb first, one byte
    function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/pmd_in_if.sv
// byte stream channel of the packet mode deframer
// depends on nothing
interface pmd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_start;

    modport source (output valid, output data_byte, output block_start, input ready);
    modport sink   (input valid, input data_byte, input block_start, output ready);
endinterface

FILE: rtl/core/pmd_out_if.sv
// result channel of the packet mode deframer
// depends on pmd_pkg for the id width
interface pmd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [pmd_pkg::ID_W-1:0]     stream_id;
    logic [7:0]                   payload;
    logic                         crc_good;
    logic                         first_mark;
    logic                         last_mark;
    logic                         sequence_good;
    logic                         length_error;
    logic                         unit_complete;

    modport source (
        output valid, output kind, output stream_id, output payload, output crc_good,
        output first_mark, output last_mark, output sequence_good, output length_error,
        output unit_complete, input ready
    );
    modport sink (
        input valid, input kind, input stream_id, input payload, input crc_good,
        input first_mark, input last_mark, input sequence_good, input length_error,
        input unit_complete, output ready
    );
endinterface

FILE: rtl/core/packet_mode_deframer_unit.sv
// packet mode deframer top level: header parse, crc-16 check, per-id continuity
// depends on pmd_pkg, pmd_in_if, pmd_out_if and packet_mode_deframer_unit_defines.svh

// packet mode deframer. takes one stream byte per beat and splits the stream
// into packets of one header byte, packet_len data bytes and a crc-16 sent
// high byte first (ccitt 0x1021, preset ones, inverted). useful data bytes
// leave at once as tentative beats (kind 0); the low crc byte yields a
// verdict beat (kind 1) with crc, continuity, length and unit complete flags.
// block_start on a byte makes it the header of a new packet and drops any
// unfinished packet. per-id continuity and unit state change only on a good
// crc; packet_len 0 acts as 1. rate: one byte per clock unless the output
// stalls. the byte-wide crc update and header logic between the input
// register and the result register are combinational and set the rate.
// a result waiting at the output stalls the input only when the input
// register is also full. packet_len must be written through cfg_wr_en /
// cfg_wr_data only while the block is idle, which the block does not check.
`include "packet_mode_deframer_unit_defines.svh"

module packet_mode_deframer_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    pmd_in_if.sink           byte_ch,
    pmd_out_if.source        result_ch
);

    localparam int unsigned NS    = pmd_pkg::NUM_STREAMS;
    localparam int unsigned ID_W  = pmd_pkg::ID_W;
    localparam int unsigned POS_W = pmd_pkg::POS_W;

    // configuration
    logic [7:0] packet_len_reg;

    // input register
    logic                 s1_valid_reg, s1_valid_next;
    pmd_pkg::pmd_item_t   s1_item_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    pmd_pkg::pmd_result_t out_res_reg;

    // deframer state
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [7:0]       header_hold_reg, header_hold_next;
    logic [7:0]       pad_count_reg, pad_count_next;
    logic [15:0]      crc_register_reg, crc_register_next;
    logic [7:0]       received_crc_high_reg, received_crc_high_next;
    logic [2:0]       sequence_index_reg [NS];
    logic [2:0]       sequence_index_next [NS];
    logic             unit_valid_reg [NS];
    logic             unit_valid_next [NS];

    // combinational work on the held byte
    logic                 in_accept;
    logic                 s1_advance;
    logic [POS_W-1:0]     pos;
    logic [7:0]           len8;
    logic [7:0]           len_m1;
    logic [POS_W-1:0]     len9;
    logic [7:0]           b;
    logic [ID_W-1:0]      hdr_id;
    logic                 hdr_first, hdr_last, hdr_pad;
    logic [2:0]           hdr_ci;
    logic                 lerr;
    logic                 id_ok;
    logic [15:0]          crc_step;
    logic                 crc_match;
    logic                 seq_ok;
    logic                 unit_v, unit_ready;
    logic                 emit;
    logic                 res_valid;
    pmd_pkg::pmd_result_t res;

    // handshake: the input register moves on whenever the result register can take a beat
    assign s1_advance      = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign byte_ch.ready   = !s1_valid_reg || s1_advance;
    assign in_accept       = byte_ch.valid && byte_ch.ready;

    assign s1_valid_next   = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next  = (s1_advance && res_valid) ? 1'b1
                           : (result_ch.ready ? 1'b0 : out_valid_reg);

    // field decode of the held header
    assign b         = s1_item_reg.data_byte;
    assign pos       = s1_item_reg.block_start ? '0 : byte_position_reg;
    assign len8      = (packet_len_reg == 8'd0) ? 8'd1 : packet_len_reg;
    assign len_m1    = len8 - 8'd1;
    assign len9      = POS_W'(len8);
    assign hdr_id    = header_hold_reg[pmd_pkg::HDR_ID_HI:pmd_pkg::HDR_ID_LO];
    assign hdr_first = header_hold_reg[pmd_pkg::HDR_FIRST];
    assign hdr_last  = header_hold_reg[pmd_pkg::HDR_LAST];
    assign hdr_pad   = header_hold_reg[pmd_pkg::HDR_PAD];
    assign hdr_ci    = header_hold_reg[2:0];
    assign lerr      = hdr_pad && (pad_count_reg > len_m1);
    assign id_ok     = 32'(hdr_id) < NS;
    assign crc_step  = pmd_pkg::crc_add((pos == '0) ? pmd_pkg::CRC_PRESET : crc_register_reg, b);
    assign crc_match = (~crc_register_reg) == {received_crc_high_reg, b};

    // continuity and unit bookkeeping for the verdict
    always_comb
    begin
        seq_ok     = 1'b0;
        unit_v     = 1'b0;
        unit_ready = 1'b0;
        if (id_ok)
        begin
            seq_ok = ((sequence_index_reg[hdr_id] + 3'd1) & pmd_pkg::SEQ_MASK) == hdr_ci;
            unit_v = unit_valid_reg[hdr_id];
            if (!seq_ok)
                unit_v = 1'b0;
            if (hdr_first)
                unit_v = 1'b1;
            unit_ready = hdr_last && unit_v;
            if (lerr)
            begin
                unit_v     = 1'b0;
                unit_ready = 1'b0;
            end
            if (hdr_pad && hdr_first && hdr_last && (pad_count_reg == 8'd0))
                unit_ready = 1'b0;
            if (unit_ready)
                unit_v = 1'b0;
        end
    end

    // data field byte emit decision
    always_comb
    begin
        if (hdr_pad)
        begin
            if (pos == POS_W'(1))
                emit = 1'b0;
            else
                emit = (pad_count_reg <= len_m1)
                    && ((pos - POS_W'(2)) < POS_W'(pad_count_reg));
        end
        else
        begin
            emit = 1'b1;
        end
    end

    // next state and result of the held byte
    always_comb
    begin
        byte_position_next     = byte_position_reg;
        header_hold_next       = header_hold_reg;
        pad_count_next         = pad_count_reg;
        crc_register_next      = crc_register_reg;
        received_crc_high_next = received_crc_high_reg;
        sequence_index_next    = sequence_index_reg;
        unit_valid_next        = unit_valid_reg;
        res                    = '0;
        res_valid              = 1'b0;
        if (s1_advance)
        begin
            priority if (pos == '0)
            begin
                // header byte
                header_hold_next   = b;
                pad_count_next     = 8'd0;
                crc_register_next  = crc_step;
                byte_position_next = POS_W'(1);
            end
            else if (pos <= len9)
            begin
                // data field byte
                crc_register_next  = crc_step;
                byte_position_next = pos + POS_W'(1);
                if (hdr_pad && (pos == POS_W'(1)))
                    pad_count_next = b;
                if (emit)
                begin
                    res_valid     = 1'b1;
                    res.kind      = pmd_pkg::KIND_DATA;
                    res.stream_id = hdr_id;
                    res.payload   = b;
                end
            end
            else if (pos == len9 + POS_W'(1))
            begin
                // high crc byte
                received_crc_high_next = b;
                byte_position_next     = pos + POS_W'(1);
            end
            else
            begin
                // low crc byte closes the packet
                res_valid         = 1'b1;
                res.kind          = pmd_pkg::KIND_VERDICT;
                res.stream_id     = hdr_id;
                res.crc_good      = crc_match;
                res.first_mark    = hdr_first;
                res.last_mark     = hdr_last;
                res.length_error  = lerr;
                if (crc_match && id_ok)
                begin
                    res.sequence_good           = seq_ok;
                    res.unit_complete           = unit_ready;
                    sequence_index_next[hdr_id] = hdr_ci;
                    unit_valid_next[hdr_id]     = unit_v;
                end
                byte_position_next = '0;
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_len_reg        <= pmd_pkg::PACKET_LEN_RESET;
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            byte_position_reg     <= '0;
            header_hold_reg       <= 8'd0;
            pad_count_reg         <= 8'd0;
            crc_register_reg      <= pmd_pkg::CRC_PRESET;
            received_crc_high_reg <= 8'd0;
            for (int i = 0; i < NS; i++)
            begin
                sequence_index_reg[i] <= 3'd0;
                unit_valid_reg[i]     <= 1'b0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                packet_len_reg <= cfg_wr_data;
            s1_valid_reg          <= s1_valid_next;
            out_valid_reg         <= out_valid_next;
            byte_position_reg     <= byte_position_next;
            header_hold_reg       <= header_hold_next;
            pad_count_reg         <= pad_count_next;
            crc_register_reg      <= crc_register_next;
            received_crc_high_reg <= received_crc_high_next;
            sequence_index_reg    <= sequence_index_next;
            unit_valid_reg        <= unit_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.data_byte   <= byte_ch.data_byte;
            s1_item_reg.block_start <= byte_ch.block_start;
        end
        if (s1_advance && res_valid)
            out_res_reg <= res;
    end

    // output beat
    assign result_ch.valid         = out_valid_reg;
    assign result_ch.kind          = out_res_reg.kind;
    assign result_ch.stream_id     = out_res_reg.stream_id;
    assign result_ch.payload       = out_res_reg.payload;
    assign result_ch.crc_good      = out_res_reg.crc_good;
    assign result_ch.first_mark    = out_res_reg.first_mark;
    assign result_ch.last_mark     = out_res_reg.last_mark;
    assign result_ch.sequence_good = out_res_reg.sequence_good;
    assign result_ch.length_error  = out_res_reg.length_error;
    assign result_ch.unit_complete = out_res_reg.unit_complete;

    // a bad crc verdict never claims continuity or a complete unit
    `PMD_ASSERT_NOW(a_bad_crc_quiet,
        out_valid_reg && (out_res_reg.kind == pmd_pkg::KIND_VERDICT) && !out_res_reg.crc_good,
        !out_res_reg.sequence_good && !out_res_reg.unit_complete)
    // data beats carry no verdict flags
    `PMD_ASSERT_NOW(a_data_no_flags,
        out_valid_reg && (out_res_reg.kind == pmd_pkg::KIND_DATA),
        !out_res_reg.crc_good && !out_res_reg.unit_complete && !out_res_reg.length_error)
    // a complete unit needs a good crc and the last flag
    `PMD_ASSERT_NOW(a_complete_needs_last,
        out_valid_reg && out_res_reg.unit_complete,
        out_res_reg.crc_good && out_res_reg.last_mark)
    // after a verdict the next byte is a header
    `PMD_ASSERT_NEXT(a_verdict_realigns,
        s1_advance && res_valid && (res.kind == pmd_pkg::KIND_VERDICT),
        byte_position_reg == '0)

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench of packet_mode_deframer_unit: directed and random packet traffic
// depends on pmd_pkg, pmd_in_if, pmd_out_if and the deframer rtl

module tb;

    // no beat on either channel for this many cycles ends the run
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    pmd_in_if  byte_if ();
    pmd_out_if res_if ();

    packet_mode_deframer_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_ch     (byte_if),
        .result_ch   (res_if)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // stream bytes waiting for the driver, beats the deframer owes us
    pmd_pkg::pmd_item_t   pending_bytes[$];
    pmd_pkg::pmd_result_t expected_beats[$];
    int unsigned mismatch_count = 0;
    int unsigned queued_bytes = 0;

    // deframer state as we expect it, plus the packet_len register copy
    logic [7:0]  frame_len;
    logic [8:0]  frm_pos;
    logic [7:0]  frm_hdr;
    logic [7:0]  frm_pad;
    logic [15:0] frm_crc;
    logic [7:0]  frm_crc_hi;
    logic [2:0]  last_ci[pmd_pkg::NUM_STREAMS];
    logic        unit_open[pmd_pkg::NUM_STREAMS];

    // continuity index the generator puts on the next packet of each id
    logic [2:0]  gen_ci[pmd_pkg::NUM_STREAMS];

    // ccitt crc-16, msb first, one byte at a time
    function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        repeat (8)
            r = r[15] ? ({r[14:0], 1'b0} ^ pmd_pkg::CRC_POLY) : {r[14:0], 1'b0};
        return r;
    endfunction

    // advance the expected deframer by one accepted byte, queue any beat it owes
    function automatic void deframe_byte(input logic [7:0] b, input logic bs);
        int unsigned flen;
        int unsigned pos;
        logic [1:0]  sid;
        logic        padded;
        logic        fst;
        logic        lst;
        logic [2:0]  ci;
        logic        lerr;
        logic        emit;
        logic        good;
        logic        seq;
        logic        done;
        logic        rdy;
        pmd_pkg::pmd_result_t r;

        flen = (frame_len == 8'd0) ? 1 : frame_len;
        r = '0;
        if (bs)
            frm_pos = '0;

        // header byte: latch it and restart the crc
        if (frm_pos == 0)
        begin
            frm_hdr = b;
            frm_pad = 8'd0;
            frm_crc = crc16_byte(pmd_pkg::CRC_PRESET, b);
            frm_pos = 9'd1;
            return;
        end

        sid    = frm_hdr[pmd_pkg::HDR_ID_HI:pmd_pkg::HDR_ID_LO];
        padded = frm_hdr[pmd_pkg::HDR_PAD];
        fst    = frm_hdr[pmd_pkg::HDR_FIRST];
        lst    = frm_hdr[pmd_pkg::HDR_LAST];
        ci     = frm_hdr[2:0];
        lerr   = padded && (frm_pad > flen - 1);

        // data field: first byte of a padded field is the useful byte count
        if (frm_pos <= flen)
        begin
            pos = frm_pos;
            frm_crc = crc16_byte(frm_crc, b);
            frm_pos = frm_pos + 9'd1;
            if (padded)
            begin
                if (pos == 1)
                begin
                    frm_pad = b;
                    emit = 1'b0;
                end
                else
                    emit = (frm_pad <= flen - 1) && (pos - 2 < frm_pad);
            end
            else
                emit = 1'b1;
            if (emit)
            begin
                r.kind      = pmd_pkg::KIND_DATA;
                r.stream_id = sid;
                r.payload   = b;
                expected_beats.push_back(r);
            end
            return;
        end

        if (frm_pos == flen + 1)
        begin
            frm_crc_hi = b;
            frm_pos = frm_pos + 9'd1;
            return;
        end

        // low crc byte, or any byte past the field after a length change: verdict
        good = (~frm_crc) == {frm_crc_hi, b};
        seq  = 1'b0;
        done = 1'b0;
        if (good && sid < pmd_pkg::NUM_STREAMS)
        begin
            seq = (last_ci[sid] + 3'd1) == ci;
            if (!seq)
                unit_open[sid] = 1'b0;
            last_ci[sid] = ci;
            if (fst)
                unit_open[sid] = 1'b1;
            rdy = lst && unit_open[sid];
            if (lerr)
            begin
                unit_open[sid] = 1'b0;
                rdy = 1'b0;
            end
            // first and last with zero useful bytes delivers nothing
            if (padded && fst && lst && frm_pad == 8'd0)
                rdy = 1'b0;
            if (rdy)
            begin
                done = 1'b1;
                unit_open[sid] = 1'b0;
            end
        end
        r.kind          = pmd_pkg::KIND_VERDICT;
        r.stream_id     = sid;
        r.crc_good      = good;
        r.first_mark    = fst;
        r.last_mark     = lst;
        r.sequence_good = seq;
        r.length_error  = lerr;
        r.unit_complete = done;
        expected_beats.push_back(r);
        frm_pos = '0;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic bs);
        pmd_pkg::pmd_item_t it;
        it.data_byte   = b;
        it.block_start = bs;
        pending_bytes.push_back(it);
        queued_bytes++;
    endfunction

    // one packet at the current length; cut >= 0 stops after that many field bytes
    function automatic void queue_packet(input logic [7:0] hdr, input int cnt,
                                         input bit bad_crc, input bit bs, input int cut);
        int unsigned flen;
        logic [15:0] c;
        logic [7:0]  f;
        flen = (frame_len == 8'd0) ? 1 : frame_len;
        c = crc16_byte(pmd_pkg::CRC_PRESET, hdr);
        queue_byte(hdr, bs);
        if (cut == 0)
            return;
        for (int i = 0; i < flen; i++)
        begin
            f = (hdr[pmd_pkg::HDR_PAD] && i == 0) ? cnt[7:0] : 8'($urandom);
            c = crc16_byte(c, f);
            queue_byte(f, 1'b0);
            if (cut > 0 && i + 1 >= cut)
                return;
        end
        c = ~c;
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        queue_byte(c[15:8], 1'b0);
        queue_byte(c[7:0], 1'b0);
    endfunction

    // mostly well-formed data units with random content, some damage and noise
    function automatic void queue_random_traffic(input int n_bytes);
        int unsigned stop;
        int unsigned flen;
        int          pick;
        int          units;
        int          cnt;
        logic [1:0]  sid;
        logic        pad;
        bit          sync;
        stop = queued_bytes + n_bytes;
        sync = 1'b1;
        flen = (frame_len == 8'd0) ? 1 : frame_len;
        while (queued_bytes < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // data unit of one to three packets on one id
                sid   = 2'($urandom_range(0, 3));
                units = $urandom_range(1, 3);
                for (int i = 0; i < units; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        gen_ci[sid] = 3'($urandom_range(0, 7));
                    else
                        gen_ci[sid] = gen_ci[sid] + 3'd1;
                    pad = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 3))
                        0:       cnt = 0;
                        1:       cnt = flen - 1;
                        default: cnt = $urandom_range(0, flen - 1);
                    endcase
                    queue_packet({i == 0, i == units - 1, sid, pad, gen_ci[sid]}, cnt, 1'b0,
                                 sync || ($urandom_range(0, 4) == 0), -1);
                    sync = 1'b0;
                end
            end
            else if (pick < 78)
            begin
                queue_packet(8'($urandom), $urandom_range(0, 255), 1'b1, sync, -1);
                sync = 1'b0;
            end
            else if (pick < 85)
            begin
                // padding count beyond the field, crc mostly good
                queue_packet(8'($urandom) | 8'h08, $urandom_range(255, flen), 
                             $urandom_range(0, 3) == 0, sync, -1);
                sync = 1'b0;
            end
            else if (pick < 92)
            begin
                // unfinished packet, the next one restarts alignment
                queue_packet(8'($urandom), $urandom_range(0, 255), 1'b0, sync,
                             $urandom_range(0, flen - 1));
                sync = 1'b1;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
                sync = 1'b1;
            end
        end
    endfunction

    // hold off until everything sent has been answered, then let the pipe settle
    task automatic wait_quiet(input int settle);
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || byte_if.valid || expected_beats.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_frame_len(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        frame_len = v;
    endtask

    // sender: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    pmd_pkg::pmd_item_t next_item;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_if.valid       <= 1'b0;
            byte_if.data_byte   <= 8'd0;
            byte_if.block_start <= 1'b0;
        end
        else if (!byte_if.valid || byte_if.ready)
        begin
            if (gap_left > 0 || pending_bytes.size() == 0)
            begin
                byte_if.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                next_item = pending_bytes.pop_front();
                byte_if.valid       <= 1'b1;
                byte_if.data_byte   <= next_item.data_byte;
                byte_if.block_start <= next_item.block_start;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
        end
    end

    // receiver: switches between always ready, coin flips and a rotating stall mask
    rx_mode_t    rx_mode = RX_ALWAYS;
    int unsigned rx_left = 0;
    logic [15:0] rx_mask = 16'hFFFF;

    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 120);
                rx_mask = 16'($urandom) | 16'h0001;
            end
            else
                rx_left--;
            case (rx_mode)
                RX_ALWAYS: res_if.ready <= 1'b1;
                RX_RANDOM: res_if.ready <= ($urandom_range(0, 9) < 6);
                default:
                begin
                    res_if.ready <= rx_mask[0];
                    rx_mask = {rx_mask[0], rx_mask[15:1]};
                end
            endcase
        end
    end

    // every accepted byte goes through the expected deframer
    always @(posedge clk)
    begin
        if (rst_n && byte_if.valid && byte_if.ready)
            deframe_byte(byte_if.data_byte, byte_if.block_start);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result monitor: each beat against the oldest expectation, field by field
    pmd_pkg::pmd_result_t want_beat;

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual kind %0b id %0d payload %0h",
                         $time, res_if.kind, res_if.stream_id, res_if.payload);
                mismatch_count++;
            end
            else
            begin
                want_beat = expected_beats.pop_front();
                check_field("kind", want_beat.kind, res_if.kind);
                check_field("stream_id", want_beat.stream_id, res_if.stream_id);
                check_field("payload", want_beat.payload, res_if.payload);
                check_field("crc_good", want_beat.crc_good, res_if.crc_good);
                check_field("first_mark", want_beat.first_mark, res_if.first_mark);
                check_field("last_mark", want_beat.last_mark, res_if.last_mark);
                check_field("sequence_good", want_beat.sequence_good, res_if.sequence_good);
                check_field("length_error", want_beat.length_error, res_if.length_error);
                check_field("unit_complete", want_beat.unit_complete, res_if.unit_complete);
            end
        end
    end

    // watchdog on cycles without a beat on either side
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, expected_beats.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'd0;

        // expected state after reset
        frame_len  = pmd_pkg::PACKET_LEN_RESET;
        frm_pos    = '0;
        frm_hdr    = 8'd0;
        frm_pad    = 8'd0;
        frm_crc    = pmd_pkg::CRC_PRESET;
        frm_crc_hi = 8'd0;
        for (int i = 0; i < pmd_pkg::NUM_STREAMS; i++)
        begin
            last_ci[i]   = 3'd0;
            unit_open[i] = 1'b0;
            gen_ci[i]    = 3'd0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unfinished packet at the reset length of 10, four field bytes in
        queue_packet({1'b1, 1'b0, 2'd1, 1'b0, 3'd1}, 0, 1'b0, 1'b1, 4);
        wait_quiet(4);

        // length drops to 1 mid-packet: the next byte is past the field, so it ends it
        write_frame_len(8'd1);
        queue_byte(8'hA5, 1'b0);
        // id 3, first and last, plain data: unit completes
        queue_packet({1'b1, 1'b1, 2'd3, 1'b0, 3'd1}, 0, 1'b0, 1'b1, -1);
        // empty padded packet, first and last with zero useful bytes
        queue_packet({1'b1, 1'b1, 2'd0, 1'b1, 3'd1}, 0, 1'b0, 1'b0, -1);
        // corrupted crc leaves the id state alone
        queue_packet({1'b1, 1'b1, 2'd1, 1'b0, 3'd1}, 0, 1'b1, 1'b0, -1);
        // padding count far beyond a one byte field
        queue_packet({1'b1, 1'b0, 2'd2, 1'b1, 3'd1}, 255, 1'b0, 1'b0, -1);
        // block start mid-packet drops the first packet without a verdict
        queue_packet({1'b1, 1'b0, 2'd2, 1'b0, 3'd7}, 0, 1'b0, 1'b0, 1);
        queue_packet({1'b1, 1'b1, 2'd2, 1'b0, 3'd2}, 0, 1'b0, 1'b1, -1);
        wait_quiet(4);

        // random traffic at the short extremes, one full padded packet at the longest
        // field, then a spread of small lengths
        queue_random_traffic(40);
        wait_quiet(4);
        write_frame_len(8'd0);
        queue_random_traffic(30);
        wait_quiet(4);
        write_frame_len(8'd255);
        queue_packet({1'b1, 1'b1, 2'd1, 1'b1, 3'd3}, 254, 1'b0, 1'b1, -1);
        wait_quiet(4);
        for (int p = 0; p < 3; p++)
        begin
            write_frame_len(8'($urandom_range(2, 12)));
            queue_random_traffic(20);
            // sender holds back until every owed beat is out
            wait_quiet(0);
            queue_random_traffic(20);
            wait_quiet(4);
        end

        wait_quiet(8);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
